>>> src/whm_pkg.sv
// Shared types, constants and codes of the weighted neighbourhood heat map unit.
package whm_pkg;

  localparam int GRID_COLS_DEF   = 64;
  localparam int GRID_ROWS_DEF   = 64;
  localparam int EDGE_MARGIN_DEF = 1;

  localparam int WEIGHT_W    = 8;
  localparam int HEAT_W      = 8;
  localparam int COORD_W     = 8;
  localparam int FLAGS_W     = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;

  localparam logic [HEAT_W-1:0] HEAT_MAX = 8'd255;

  localparam logic [WEIGHT_W-1:0] LAVA_CENTRE_RST = 8'd10;
  localparam logic [WEIGHT_W-1:0] FIRE_CENTRE_RST = 8'd5;
  localparam logic [WEIGHT_W-1:0] BRAZIER_RST     = 8'd5;
  localparam logic [WEIGHT_W-1:0] SPILL_RST       = 8'd1;

  // bit positions of the stored source flags
  localparam int FLAG_LAVA    = 0;
  localparam int FLAG_FIRE    = 1;
  localparam int FLAG_BRAZIER = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_LAVA_CENTRE = 2'd0,
    REG_FIRE_CENTRE = 2'd1,
    REG_BRAZIER     = 2'd2,
    REG_SPILL       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] lava_centre;
    logic [WEIGHT_W-1:0] fire_centre;
    logic [WEIGHT_W-1:0] brazier;
    logic [WEIGHT_W-1:0] spill;
  } cfg_t;

  typedef struct packed {
    logic clear;      // clear one memory entry and advance the sweep
    logic capture;    // take the input transfer into the item registers
    logic mem_write;  // store the captured flags
    logic gather;     // read one neighbour and advance the neighbour counters
    logic load_out;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_read;
    logic in_grid;
    logic nb_last;
    logic out_busy;
  } status_t;

endpackage

>>> src/weighted_neighbourhood_heat_map_unit.sv
// Top level of the weighted neighbourhood heat map unit.
// Holds lava, fire and brazier flags for a GRID_COLS x GRID_ROWS grid in a memory whose
// writes and reads use separate ports. After reset the memory is swept clear, one cell a
// cycle, over all GRID_COLS*GRID_ROWS cells (4096 at the defaults) with s_axis_tready low;
// configuration writes are taken throughout. One item is in work at a time. For a read
// inside the grid the nine neighbour cells are fetched one per cycle through the memory's
// single read port, the last fetch is summed in the following cycle, then the result moves
// to the output register once it is free. A read outside the grid returns heat 0 with
// outside_map set. The output register lets the next item be accepted while a result waits.
module weighted_neighbourhood_heat_map_unit #(
  parameter int GRID_COLS   = whm_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS   = whm_pkg::GRID_ROWS_DEF,
  parameter int EDGE_MARGIN = whm_pkg::EDGE_MARGIN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] cell_col, [15:8] cell_row, [16] has_lava, [17] has_fire, [18] has_brazier
  input  logic [whm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] opcode
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] heat
  output logic [whm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // [0] outside_map
  output logic                                m_axis_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [whm_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [whm_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [whm_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  whm_pkg::cfg_t     cfg;
  whm_pkg::cmd_t     cmd;
  whm_pkg::status_t  status;

  assign pready = 1'b1;

  whm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  whm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  whm_dp #(
    .GRID_COLS   (GRID_COLS),
    .GRID_ROWS   (GRID_ROWS),
    .EDGE_MARGIN (EDGE_MARGIN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_i         (cfg),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> src/whm_regs.sv
// Weight registers behind the APB-style configuration port.
module whm_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [whm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [whm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [whm_pkg::CFG_DATA_W-1:0]     prdata,
  output whm_pkg::cfg_t                      cfg_o
);

  whm_pkg::cfg_t      cfg_q;
  whm_pkg::reg_idx_e  idx;
  logic               wr_en;

  assign idx   = whm_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lava_centre <= whm_pkg::LAVA_CENTRE_RST;
      cfg_q.fire_centre <= whm_pkg::FIRE_CENTRE_RST;
      cfg_q.brazier     <= whm_pkg::BRAZIER_RST;
      cfg_q.spill       <= whm_pkg::SPILL_RST;
    end else if (wr_en) begin
      unique case (idx)
        whm_pkg::REG_LAVA_CENTRE: cfg_q.lava_centre <= pwdata[whm_pkg::WEIGHT_W-1:0];
        whm_pkg::REG_FIRE_CENTRE: cfg_q.fire_centre <= pwdata[whm_pkg::WEIGHT_W-1:0];
        whm_pkg::REG_BRAZIER:     cfg_q.brazier     <= pwdata[whm_pkg::WEIGHT_W-1:0];
        whm_pkg::REG_SPILL:       cfg_q.spill       <= pwdata[whm_pkg::WEIGHT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      whm_pkg::REG_LAVA_CENTRE: prdata = whm_pkg::CFG_DATA_W'(cfg_q.lava_centre);
      whm_pkg::REG_FIRE_CENTRE: prdata = whm_pkg::CFG_DATA_W'(cfg_q.fire_centre);
      whm_pkg::REG_BRAZIER:     prdata = whm_pkg::CFG_DATA_W'(cfg_q.brazier);
      whm_pkg::REG_SPILL:       prdata = whm_pkg::CFG_DATA_W'(cfg_q.spill);
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/whm_dp.sv
// Datapath: item registers, flag memory, neighbour walk, saturating sum and output register.
module whm_dp #(
  parameter int GRID_COLS   = whm_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS   = whm_pkg::GRID_ROWS_DEF,
  parameter int EDGE_MARGIN = whm_pkg::EDGE_MARGIN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  whm_pkg::cmd_t                       cmd_i,
  output whm_pkg::status_t                    status_o,
  input  whm_pkg::cfg_t                       cfg_i,
  input  logic [whm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  logic                                m_axis_tready,
  output logic                                m_axis_tvalid,
  output logic [whm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser
);

  localparam int Depth = GRID_COLS * GRID_ROWS;
  localparam int AddrW = $clog2(Depth);
  localparam int LinW  = 18;
  // bounds on coordinates held with an offset of one, so no negative values arise
  localparam logic [8:0] ColLo = 9'(EDGE_MARGIN + 1);
  localparam logic [8:0] ColHi = 9'(GRID_COLS - EDGE_MARGIN + 1);
  localparam logic [8:0] RowLo = 9'(EDGE_MARGIN + 1);
  localparam logic [8:0] RowHi = 9'(GRID_ROWS - EDGE_MARGIN + 1);

  logic [whm_pkg::FLAGS_W-1:0] mem [Depth];

  logic [whm_pkg::COORD_W-1:0] col_q, row_q;
  logic [whm_pkg::FLAGS_W-1:0] flags_q;
  logic                        is_read_q;
  logic [1:0]                  dx_q, dy_q;
  logic [AddrW-1:0]            clr_cnt_q;

  logic [whm_pkg::FLAGS_W-1:0] rd_data_q;
  logic                        rd_vld_q, rd_centre_q, rd_counted_q;
  logic [whm_pkg::HEAT_W-1:0]  sum_q, sum_d;

  logic                        out_vld_q, outside_q;
  logic [whm_pkg::HEAT_W-1:0]  heat_q;

  logic [8:0]                  sc1, sr1;
  logic                        counted, centre, in_grid;
  logic [LinW-1:0]             nb_lin, wr_lin;
  logic [AddrW-1:0]            nb_addr, wr_addr;
  logic [8:0]                  add;
  logic [9:0]                  total;

  assign sc1     = {1'b0, col_q} + {7'b0, dx_q};
  assign sr1     = {1'b0, row_q} + {7'b0, dy_q};
  assign counted = (sc1 >= ColLo) && (sc1 < ColHi) && (sr1 >= RowLo) && (sr1 < RowHi);
  assign centre  = (dx_q == 2'd1) && (dy_q == 2'd1);
  assign in_grid = ({1'b0, col_q} < 9'(GRID_COLS)) && ({1'b0, row_q} < 9'(GRID_ROWS));

  assign nb_lin  = LinW'(sr1 - 9'd1) * LinW'(GRID_COLS) + LinW'(sc1 - 9'd1);
  assign wr_lin  = LinW'(row_q) * LinW'(GRID_COLS) + LinW'(col_q);
  assign nb_addr = nb_lin[AddrW-1:0];
  assign wr_addr = wr_lin[AddrW-1:0];

  // contribution of the neighbour read in the previous cycle
  always_comb begin
    add = '0;
    if (rd_counted_q) begin
      if (rd_data_q[whm_pkg::FLAG_LAVA]) begin
        add = add + 9'(rd_centre_q ? cfg_i.lava_centre : cfg_i.spill);
      end
      if (rd_data_q[whm_pkg::FLAG_BRAZIER]) begin
        if (rd_centre_q) begin
          add = add + 9'(cfg_i.brazier);
        end
      end else if (rd_data_q[whm_pkg::FLAG_FIRE]) begin
        add = add + 9'(rd_centre_q ? cfg_i.fire_centre : cfg_i.spill);
      end
    end
    total = {2'b0, sum_q} + {1'b0, add};
    sum_d = (total > 10'(whm_pkg::HEAT_MAX)) ? whm_pkg::HEAT_MAX : total[whm_pkg::HEAT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[clr_cnt_q] <= '0;
    end else if (cmd_i.mem_write) begin
      mem[wr_addr] <= flags_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gather) begin
      rd_data_q <= mem[nb_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q     <= s_axis_tdata[7:0];
      row_q     <= s_axis_tdata[15:8];
      flags_q   <= s_axis_tdata[18:16];
      is_read_q <= (s_axis_tuser == whm_pkg::OP_READ);
    end
    if (cmd_i.gather) begin
      rd_centre_q  <= centre;
      rd_counted_q <= counted;
    end
    if (cmd_i.load_out) begin
      heat_q    <= in_grid ? sum_q : '0;
      outside_q <= !in_grid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dx_q      <= '0;
      dy_q      <= '0;
      clr_cnt_q <= '0;
      rd_vld_q  <= 1'b0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.gather;
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
      if (cmd_i.capture) begin
        dx_q  <= '0;
        dy_q  <= '0;
        sum_q <= '0;
      end else begin
        if (cmd_i.gather) begin
          if (dx_q == 2'd2) begin
            dx_q <= '0;
            dy_q <= dy_q + 2'd1;
          end else begin
            dx_q <= dx_q + 2'd1;
          end
        end
        if (rd_vld_q) begin
          sum_q <= sum_d;
        end
      end
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign status_o.clear_last = (clr_cnt_q == AddrW'(Depth - 1));
  assign status_o.is_read    = is_read_q;
  assign status_o.in_grid    = in_grid;
  assign status_o.nb_last    = (dx_q == 2'd2) && (dy_q == 2'd2);
  assign status_o.out_busy   = out_vld_q && !m_axis_tready;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = heat_q;
  assign m_axis_tuser  = outside_q;

endmodule

>>> src/whm_ctrl.sv
// Controller: clearing sweep, item dispatch, neighbour walk and result hand-off.
module whm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  whm_pkg::status_t  status_i,
  output whm_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_GATHER,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (!status_i.is_read) begin
          // writes outside the grid are dropped
          cmd_o.mem_write = status_i.in_grid;
          state_d         = ST_IDLE;
        end else if (status_i.in_grid) begin
          state_d = ST_GATHER;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_GATHER: begin
        cmd_o.gather = 1'b1;
        if (status_i.nb_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

endmodule

>>> src/whm_checker.sv
// Port-level checker of the heat map unit and its binding to the top level.
module whm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [whm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input logic                                m_axis_tuser
);

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an outside read carries no heat
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("outside read with non-zero heat");

  // one item at a time: ready drops after each transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  // no result can appear in the cycle right after an item transfer
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result raised straight after an item transfer");

endmodule

bind weighted_neighbourhood_heat_map_unit whm_checker u_whm_checker (.*);

>>> sim/tb.sv
// Self-checking testbench for the weighted neighbourhood heat map unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import whm_pkg::*;

  localparam int GRID_COLS    = GRID_COLS_DEF;
  localparam int GRID_ROWS    = GRID_ROWS_DEF;
  localparam int EDGE_MARGIN  = EDGE_MARGIN_DEF;
  localparam int SETTLE_CYCLES = 20;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_SHOWN     = 10;

  typedef struct packed {
    logic [HEAT_W-1:0] heat;
    logic              outside;
  } heat_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [CFG_DATA_W-1:0]  pwdata;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  // shadow copy of the grid and the weights
  logic [FLAGS_W-1:0] cell_flags [GRID_COLS*GRID_ROWS];
  cfg_t               weights;
  heat_result_t       heat_expect_q [$];

  bit gaps_on;
  int err_cnt;
  int cycle_cnt;
  int writes_sent;
  int reads_sent;
  int outside_reads;
  int results_seen;
  int weight_sets;

  weighted_neighbourhood_heat_map_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Run exceeded %0d cycles with %0d results outstanding", LIMIT_CYCLES,
               heat_expect_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic logic [HEAT_W-1:0] neighbourhood_heat(input int col, input int row);
    int unsigned        total;
    int                 sc;
    int                 sr;
    logic               centre;
    logic [FLAGS_W-1:0] f;
    total = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        sc     = col + dx;
        sr     = row + dy;
        centre = (dx == 0) && (dy == 0);
        if (sc >= EDGE_MARGIN && sc < GRID_COLS - EDGE_MARGIN &&
            sr >= EDGE_MARGIN && sr < GRID_ROWS - EDGE_MARGIN) begin
          f = cell_flags[sr*GRID_COLS + sc];
          if (f[FLAG_LAVA]) total += centre ? weights.lava_centre : weights.spill;
          // a brazier keeps its heat to itself and smothers the fire flag
          if (f[FLAG_BRAZIER]) begin
            if (centre) total += weights.brazier;
          end else if (f[FLAG_FIRE]) begin
            total += centre ? weights.fire_centre : weights.spill;
          end
        end
      end
    end
    return (total > HEAT_MAX) ? HEAT_MAX : total[HEAT_W-1:0];
  endfunction

  // Apply one accepted transfer to the shadow grid and queue its result.
  task automatic track_transfer(input op_e op, input logic [COORD_W-1:0] col,
                                input logic [COORD_W-1:0] row, input logic [FLAGS_W-1:0] flags);
    heat_result_t r;
    logic         in_grid;
    in_grid = (col < GRID_COLS) && (row < GRID_ROWS);
    if (op == OP_WRITE) begin
      writes_sent++;
      if (in_grid) cell_flags[row*GRID_COLS + col] = flags;
    end else begin
      reads_sent++;
      if (!in_grid) outside_reads++;
      r.outside = !in_grid;
      r.heat    = in_grid ? neighbourhood_heat(col, row) : '0;
      heat_expect_q.push_back(r);
    end
  endtask

  task automatic send_item(input op_e op, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [FLAGS_W-1:0] flags);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, flags[FLAG_BRAZIER], flags[FLAG_FIRE], flags[FLAG_LAVA], row, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_transfer(op, col, row, flags);
  endtask

  function automatic logic [FLAGS_W-1:0] make_flags(input bit lava, input bit fire,
                                                    input bit brazier);
    logic [FLAGS_W-1:0] f;
    f               = '0;
    f[FLAG_LAVA]    = lava;
    f[FLAG_FIRE]    = fire;
    f[FLAG_BRAZIER] = brazier;
    return f;
  endfunction

  // Stop sending, wait for every outstanding result, then let the block go quiet.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (heat_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_weight(input reg_idx_e idx, input logic [WEIGHT_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[WEIGHT_W-1:0] !== want)
      note_failure($sformatf("register %s read %0d, expected %0d", idx.name(),
                             prdata[WEIGHT_W-1:0], want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_weight(input reg_idx_e idx, input logic [WEIGHT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(CFG_DATA_W-WEIGHT_W){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_LAVA_CENTRE: weights.lava_centre = value;
      REG_FIRE_CENTRE: weights.fire_centre = value;
      REG_BRAZIER:     weights.brazier     = value;
      REG_SPILL:       weights.spill       = value;
      default: ;
    endcase
    // go straight into the setup phase of the read-back
    check_weight(idx, value);
  endtask

  task automatic program_weights(input logic [WEIGHT_W-1:0] lava, input logic [WEIGHT_W-1:0] fire,
                                 input logic [WEIGHT_W-1:0] brazier,
                                 input logic [WEIGHT_W-1:0] spill);
    drain_results();
    program_weight(REG_LAVA_CENTRE, lava);
    program_weight(REG_FIRE_CENTRE, fire);
    program_weight(REG_BRAZIER, brazier);
    program_weight(REG_SPILL, spill);
    weight_sets++;
  endtask

  task automatic test_register_access();
    check_weight(REG_LAVA_CENTRE, LAVA_CENTRE_RST);
    check_weight(REG_FIRE_CENTRE, FIRE_CENTRE_RST);
    check_weight(REG_BRAZIER, BRAZIER_RST);
    check_weight(REG_SPILL, SPILL_RST);
    program_weights(LAVA_CENTRE_RST, FIRE_CENTRE_RST, BRAZIER_RST, SPILL_RST);
  endtask

  // Mixed sources, the border margin, the grid edge and reads outside the grid.
  task automatic test_directed_cases();
    send_item(OP_WRITE, 8'd5, 8'd5, make_flags(1, 0, 0));
    send_item(OP_WRITE, 8'd6, 8'd5, make_flags(0, 1, 0));
    send_item(OP_WRITE, 8'd5, 8'd6, make_flags(0, 1, 1));
    send_item(OP_WRITE, 8'd6, 8'd6, make_flags(1, 0, 1));
    send_item(OP_READ, 8'd5, 8'd5, '0);
    send_item(OP_READ, 8'd6, 8'd6, '0);
    send_item(OP_READ, 8'd7, 8'd7, '0);
    send_item(OP_READ, 8'd4, 8'd4, '0);
    send_item(OP_WRITE, 8'd0, 8'd0, make_flags(1, 0, 0));
    send_item(OP_WRITE, 8'd63, 8'd63, make_flags(1, 1, 0));
    send_item(OP_READ, 8'd1, 8'd1, '0);
    send_item(OP_READ, 8'd0, 8'd0, '0);
    send_item(OP_READ, 8'd62, 8'd62, '0);
    send_item(OP_READ, 8'd63, 8'd63, '0);
    send_item(OP_WRITE, 8'd64, 8'd3, make_flags(1, 1, 1));
    send_item(OP_READ, 8'd63, 8'd3, '0);
    send_item(OP_READ, 8'd64, 8'd3, '0);
    send_item(OP_READ, 8'd3, 8'd64, '0);
    send_item(OP_READ, 8'd255, 8'd255, '0);
    send_item(OP_WRITE, 8'd255, 8'd0, make_flags(1, 1, 1));
    send_item(OP_WRITE, 8'd1, 8'd62, make_flags(1, 1, 1));
    send_item(OP_READ, 8'd1, 8'd62, '0);
    send_item(OP_READ, 8'd2, 8'd63, '0);
    send_item(OP_WRITE, 8'd5, 8'd5, '0);
    send_item(OP_READ, 8'd5, 8'd5, '0);
  endtask

  // Dense traffic in one 8x8 patch keeps neighbourhoods busy; the rest roams the full range.
  task automatic test_random_traffic(input int count, input int base_col, input int base_row);
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [FLAGS_W-1:0] flags;
    op_e                op;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        col = COORD_W'(base_col + $urandom_range(0, 7));
        row = COORD_W'(base_row + $urandom_range(0, 7));
      end else begin
        col = COORD_W'($urandom_range(0, 255));
        row = COORD_W'($urandom_range(0, 255));
      end
      op    = ($urandom_range(0, 1) == 1) ? OP_READ : OP_WRITE;
      flags = ($urandom_range(0, 2) == 0) ? '0 : FLAGS_W'($urandom_range(0, 7));
      send_item(op, col, row, flags);
    end
  endtask

  task automatic test_pause_for_results();
    test_random_traffic(30, 20, 20);
    // hold the sender until the block has delivered everything
    drain_results();
    test_random_traffic(30, 20, 20);
  endtask

  task automatic test_saturation();
    program_weights(8'd255, 8'd255, 8'd255, 8'd255);
    send_item(OP_WRITE, 8'd10, 8'd10, make_flags(1, 1, 1));
    send_item(OP_WRITE, 8'd11, 8'd10, make_flags(0, 1, 0));
    send_item(OP_READ, 8'd10, 8'd10, '0);
    send_item(OP_READ, 8'd11, 8'd11, '0);
    send_item(OP_READ, 8'd12, 8'd12, '0);
    test_random_traffic(200, 28, 30);
  endtask

  // Check each result transfer and stall the output at random.
  initial begin
    int           stall;
    heat_result_t want;
    m_axis_tready = 1'b0;
    stall         = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (heat_expect_q.size() == 0) begin
          note_failure($sformatf("result heat %0d outside %0b with nothing expected",
                                 m_axis_tdata, m_axis_tuser));
        end else begin
          want = heat_expect_q.pop_front();
          if (m_axis_tdata !== want.heat || m_axis_tuser !== want.outside)
            note_failure($sformatf("result %0d: heat %0d outside %0b, expected heat %0d outside %0b",
                                   results_seen, m_axis_tdata, m_axis_tuser, want.heat,
                                   want.outside));
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_WRITE;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cycle_cnt     = 0;
    err_cnt       = 0;
    gaps_on       = 1'b1;
    weights       = {LAVA_CENTRE_RST, FIRE_CENTRE_RST, BRAZIER_RST, SPILL_RST};
    foreach (cell_flags[i]) cell_flags[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_cases();
    test_random_traffic(200, 0, 0);
    test_pause_for_results();
    test_saturation();
    program_weights(8'd0, 8'd0, 8'd0, 8'd0);
    test_random_traffic(150, 56, 56);
    program_weights(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    test_random_traffic(200, $urandom_range(0, 60), $urandom_range(0, 60));
    program_weights(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                    8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
    test_random_traffic(200, $urandom_range(0, 60), $urandom_range(0, 60));

    // back-to-back transfers on both sides to close
    drain_results();
    gaps_on = 1'b0;
    test_random_traffic(100, $urandom_range(0, 56), $urandom_range(0, 56));
    drain_results();

    $display("Covered %0d cell writes and %0d heat reads (%0d outside the grid)",
             writes_sent, reads_sent, outside_reads);
    $display("across %0d weight settings; %0d failures", weight_sets, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/whm_pkg.sv
src/whm_regs.sv
src/whm_dp.sv
src/whm_ctrl.sv
src/weighted_neighbourhood_heat_map_unit.sv
src/whm_checker.sv
sim/tb.sv
